// ===== rtl/enthalpy_to_temperature_lever_rule_defines.svh =====
`ifndef ENTHALPY_TO_TEMPERATURE_LEVER_RULE_DEFINES_SVH
`define ENTHALPY_TO_TEMPERATURE_LEVER_RULE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ETTLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ETTLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ettlr_pkg.sv =====
package ettlr_pkg;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_ABS,
    ALU_MAX
  } alu_op_t;

  typedef struct packed {
    logic    go;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [1:0] {
    REG_LIQUID   = 2'd0,
    REG_MUSHY    = 2'd1,
    REG_EUTECTIC = 2'd2,
    REG_SOLID    = 2'd3
  } region_t;

  typedef enum logic [1:0] {
    RET_HE,
    RET_LOOP,
    RET_FINAL
  } ret_t;

  typedef enum logic [4:0] {
    SRC_CS, SRC_CF, SRC_HF, SRC_KP, SRC_TE, SRC_TM, SRC_M,
    SRC_H, SRC_CONC, SRC_T, SRC_ONE, SRC_X, SRC_Y, SRC_TN,
    SRC_INV, SRC_TLIQ, SRC_H0, SRC_F, SRC_LV, SRC_TSOL
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_X, DST_Y, DST_H0, DST_TLIQ, DST_TSOL, DST_HLIQ, DST_HSOL,
    DST_HE, DST_INV, DST_F, DST_CL, DST_T, DST_TN
  } dst_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_H0A, ST_H0B, ST_H0C,
    ST_TLA, ST_TLB,
    ST_TSA, ST_TSB, ST_TSC, ST_TSD,
    ST_HLA, ST_HLB, ST_HS,
    ST_IVA, ST_IVB,
    ST_LVA, ST_LVB, ST_LVC, ST_LVD, ST_LVE,
    ST_HEA, ST_HEB, ST_HEC,
    ST_CLS,
    ST_LQA, ST_LQB,
    ST_MFA, ST_MFB, ST_MFC, ST_MFD, ST_MFE, ST_MFF,
    ST_MFG, ST_MFH, ST_MFI, ST_MFJ, ST_MFK, ST_MCHK,
    ST_FNA, ST_FNB,
    ST_EUA, ST_EUB, ST_EUC, ST_EUD,
    ST_SDA,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    use_alu;
    alu_op_t op;
    src_t    asel;
    src_t    bsel;
    dst_t    dsel;
  } step_t;

endpackage

// ===== rtl/enthalpy_to_temperature_lever_rule.sv =====
// Enthalpy to temperature inversion for a binary alloy (lever rule).
// Command port: pulse start with enthalpy, bulk_concentration and
// guess_temperature while busy is low; the inputs are taken on that edge.
// busy stays high until the result; then done is high for exactly one cycle
// with node_temperature, liquid_fraction, liquid_concentration, phase_region,
// limit_reached and iterations_used. The receiver cannot stall: the result
// transaction completes at the edge that ends the done cycle, and start may
// be given again in that same cycle. One transaction at a time.
// Operations: one shared saturating unit does every operation. Add, subtract,
// abs and max are done directly, a multiply runs a shift-add over WORD_BITS bits
// and a divide a restoring division over WORD_BITS+FRACTION_BITS bits (a zero
// divisor saturates without dividing). At Q16.16 setup through the region test
// takes 8 multiplies and 3 divides; then the liquid, solid and eutectic paths
// finish, and mushy runs 4 multiplies and 3 divides per iteration, up to 256
// iterations at the largest iteration limit.
// Configuration: write_enable, write_index, write_data; write only while idle.
// Reset (rst, synchronous) restores register defaults and idles the sequencer.
module enthalpy_to_temperature_lever_rule import ettlr_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  parameter int WORD_BITS     = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               write_enable,
  input  logic [2:0]         write_index,
  input  logic [31:0]        write_data,
  input  logic signed [31:0] enthalpy,
  input  logic signed [31:0] bulk_concentration,
  input  logic signed [31:0] guess_temperature,
  output logic               done,
  output logic signed [31:0] node_temperature,
  output logic signed [31:0] liquid_fraction,
  output logic signed [31:0] liquid_concentration,
  output logic [1:0]         phase_region,
  output logic               limit_reached,
  output logic [8:0]         iterations_used
);

  `include "enthalpy_to_temperature_lever_rule_defines.svh"

  localparam int W  = WORD_BITS;
  localparam int XW = (W > 33) ? W : 33;
  localparam int OW = (W > 32) ? W : 32;
  localparam logic signed [XW-1:0] WMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] WMIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [OW-1:0] OMAX = {{(OW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [OW-1:0] OMIN = {{(OW-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [W-1:0] ONE_W = {{(W-1){1'b0}}, 1'b1} << FRACTION_BITS;
  localparam longint TOL_L = ((64'sd1 <<< FRACTION_BITS) + 64'sd500) / 64'sd1000;
  localparam logic signed [W-1:0] TOL_W = W'(TOL_L);

  localparam logic [2:0] IDX_CS  = 3'd0;
  localparam logic [2:0] IDX_CF  = 3'd1;
  localparam logic [2:0] IDX_HF  = 3'd2;
  localparam logic [2:0] IDX_KP  = 3'd3;
  localparam logic [2:0] IDX_TE  = 3'd4;
  localparam logic [2:0] IDX_TM  = 3'd5;
  localparam logic [2:0] IDX_M   = 3'd6;
  localparam logic [2:0] IDX_LIM = 3'd7;

  function automatic logic signed [W-1:0] to_word(input logic signed [32:0] v);
    logic signed [XW-1:0] e;
    e = XW'(v);
    if (e > WMAX_X) return WMAX_X[W-1:0];
    if (e < WMIN_X) return WMIN_X[W-1:0];
    return e[W-1:0];
  endfunction

  function automatic logic signed [31:0] to_out(input logic signed [W-1:0] v);
    logic signed [OW-1:0] e;
    e = OW'(v);
    if (e > OMAX) return 32'sh7FFFFFFF;
    if (e < OMIN) return 32'sh80000000;
    return e[31:0];
  endfunction

  // configuration registers
  logic [30:0] c_solid, c_fluid, h_latent;
  logic [15:0] k_part;
  logic [31:0] t_eut, t_melt, m_liq;
  logic [7:0]  iter_limit;

  logic signed [W-1:0] cs_w, cf_w, hf_w, kp_w, te_w, tm_w, m_w;

  // working registers
  logic signed [W-1:0] h, conc, t, x, y, tn, inv, tliq, tsol, h0, hliq, hsol, he;
  logic signed [W-1:0] f, cl, lv;
  state_t              state, state_next;
  ret_t                ret;
  region_t             region;
  logic [8:0]          cnt;
  logic                flag;
  logic                pend;
  step_t               step;
  alu_req_t            req;
  logic                alu_done;
  logic signed [W-1:0] alu_a, alu_b, alu_res;
  logic [8:0]          cnt_inc;

  assign cs_w = to_word({2'b00, c_solid});
  assign cf_w = to_word({2'b00, c_fluid});
  assign hf_w = to_word({2'b00, h_latent});
  assign kp_w = to_word({17'd0, k_part});
  assign te_w = to_word({t_eut[31], t_eut});
  assign tm_w = to_word({t_melt[31], t_melt});
  assign m_w  = to_word({m_liq[31], m_liq});
  assign cnt_inc = cnt + 9'd1;

  function automatic logic signed [W-1:0] pick(input src_t s);
    case (s)
      SRC_CS:   return cs_w;
      SRC_CF:   return cf_w;
      SRC_HF:   return hf_w;
      SRC_KP:   return kp_w;
      SRC_TE:   return te_w;
      SRC_TM:   return tm_w;
      SRC_M:    return m_w;
      SRC_H:    return h;
      SRC_CONC: return conc;
      SRC_T:    return t;
      SRC_ONE:  return ONE_W;
      SRC_X:    return x;
      SRC_Y:    return y;
      SRC_TN:   return tn;
      SRC_INV:  return inv;
      SRC_TLIQ: return tliq;
      SRC_H0:   return h0;
      SRC_F:    return f;
      SRC_LV:   return lv;
      SRC_TSOL: return tsol;
      default:  return '0;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      c_solid    <= 31'd11659;
      c_fluid    <= 31'd10138;
      h_latent   <= 31'd1976697;
      k_part     <= 16'd20316;
      t_eut      <= 32'sd11993088;
      t_melt     <= 32'sd21430272;
      m_liq      <= -32'sd15245640;
      iter_limit <= 8'd100;
    end else if (write_enable) begin
      case (write_index)
        IDX_CS:  c_solid    <= write_data[30:0];
        IDX_CF:  c_fluid    <= write_data[30:0];
        IDX_HF:  h_latent   <= write_data[30:0];
        IDX_KP:  k_part     <= write_data[15:0];
        IDX_TE:  t_eut      <= write_data;
        IDX_TM:  t_melt     <= write_data;
        IDX_M:   m_liq      <= write_data;
        IDX_LIM: iter_limit <= write_data[7:0];
        default: ;
      endcase
    end
  end

  // microcode: one ALU operation per step
  always_comb begin
    step = '{use_alu: 1'b0, op: ALU_ADD, asel: SRC_X, bsel: SRC_Y, dsel: DST_NONE};
    case (state)
      ST_H0A: step = '{1'b1, ALU_SUB, SRC_CS,  SRC_CF,   DST_X};
      ST_H0B: step = '{1'b1, ALU_MUL, SRC_X,   SRC_TE,   DST_X};
      ST_H0C: step = '{1'b1, ALU_ADD, SRC_X,   SRC_HF,   DST_H0};
      ST_TLA: step = '{1'b1, ALU_MUL, SRC_M,   SRC_CONC, DST_X};
      ST_TLB: step = '{1'b1, ALU_ADD, SRC_TM,  SRC_X,    DST_TLIQ};
      ST_TSA: step = '{1'b1, ALU_DIV, SRC_M,   SRC_KP,   DST_X};
      ST_TSB: step = '{1'b1, ALU_MUL, SRC_X,   SRC_CONC, DST_X};
      ST_TSC: step = '{1'b1, ALU_ADD, SRC_TM,  SRC_X,    DST_TSOL};
      ST_TSD: step = '{1'b1, ALU_MAX, SRC_TSOL, SRC_TE,  DST_TSOL};
      ST_HLA: step = '{1'b1, ALU_MUL, SRC_CF,  SRC_TLIQ, DST_X};
      ST_HLB: step = '{1'b1, ALU_ADD, SRC_X,   SRC_H0,   DST_HLIQ};
      ST_HS:  step = '{1'b1, ALU_MUL, SRC_CS,  SRC_TSOL, DST_HSOL};
      ST_IVA: step = '{1'b1, ALU_SUB, SRC_ONE, SRC_KP,   DST_X};
      ST_IVB: step = '{1'b1, ALU_DIV, SRC_ONE, SRC_X,    DST_INV};
      ST_LVA: step = '{1'b1, ALU_SUB, SRC_LV,  SRC_TLIQ, DST_X};
      ST_LVB: step = '{1'b1, ALU_MUL, SRC_INV, SRC_X,    DST_X};
      ST_LVC: step = '{1'b1, ALU_SUB, SRC_LV,  SRC_TM,   DST_Y};
      ST_LVD: step = '{1'b1, ALU_DIV, SRC_X,   SRC_Y,    DST_X};
      ST_LVE: step = '{1'b1, ALU_SUB, SRC_ONE, SRC_X,    DST_F};
      ST_HEA: step = '{1'b1, ALU_MUL, SRC_F,   SRC_HF,   DST_X};
      ST_HEB: step = '{1'b1, ALU_MUL, SRC_CS,  SRC_TE,   DST_Y};
      ST_HEC: step = '{1'b1, ALU_ADD, SRC_X,   SRC_Y,    DST_HE};
      ST_LQA: step = '{1'b1, ALU_SUB, SRC_H,   SRC_H0,   DST_X};
      ST_LQB: step = '{1'b1, ALU_DIV, SRC_X,   SRC_CF,   DST_T};
      ST_MFA: step = '{1'b1, ALU_MUL, SRC_F,   SRC_CF,   DST_X};
      ST_MFB: step = '{1'b1, ALU_SUB, SRC_ONE, SRC_F,    DST_Y};
      ST_MFC: step = '{1'b1, ALU_MUL, SRC_Y,   SRC_CS,   DST_Y};
      ST_MFD: step = '{1'b1, ALU_ADD, SRC_X,   SRC_Y,    DST_Y};
      ST_MFE: step = '{1'b1, ALU_MUL, SRC_F,   SRC_H0,   DST_X};
      ST_MFF: step = '{1'b1, ALU_SUB, SRC_H,   SRC_X,    DST_X};
      ST_MFG: step = '{1'b1, ALU_DIV, SRC_X,   SRC_Y,    DST_TN};
      ST_MFH: step = '{1'b1, ALU_SUB, SRC_TN,  SRC_T,    DST_X};
      ST_MFI: step = '{1'b1, ALU_ABS, SRC_X,   SRC_X,    DST_X};
      ST_MFJ: step = '{1'b1, ALU_ABS, SRC_T,   SRC_T,    DST_Y};
      ST_MFK: step = '{1'b1, ALU_DIV, SRC_X,   SRC_Y,    DST_X};
      ST_FNA: step = '{1'b1, ALU_SUB, SRC_T,   SRC_TM,   DST_X};
      ST_FNB: step = '{1'b1, ALU_DIV, SRC_X,   SRC_M,    DST_CL};
      ST_EUA: step = '{1'b1, ALU_SUB, SRC_H,   SRC_TSOL, DST_X};
      ST_EUB: step = '{1'b1, ALU_DIV, SRC_X,   SRC_HF,   DST_F};
      ST_EUC: step = '{1'b1, ALU_SUB, SRC_TE,  SRC_TM,   DST_X};
      ST_EUD: step = '{1'b1, ALU_DIV, SRC_X,   SRC_M,    DST_CL};
      ST_SDA: step = '{1'b1, ALU_DIV, SRC_H,   SRC_CS,   DST_T};
      default: ;
    endcase
  end

  // hsol subtraction in the eutectic branch uses hsol, not tsol
  assign alu_a = pick(step.asel);
  assign alu_b = (state == ST_EUA) ? hsol : pick(step.bsel);
  assign req   = '{go: step.use_alu & ~pend, op: step.op};

  ettlr_alu #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .a      (alu_a),
    .b      (alu_b),
    .done   (alu_done),
    .result (alu_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_H0A;
      ST_CLS: begin
        if (h > hliq) state_next = ST_LQA;
        else if (h > he) state_next = ST_LVA;
        else if (h > hsol) state_next = ST_EUA;
        else state_next = ST_SDA;
      end
      ST_MCHK: state_next = ST_LVA;
      ST_DONE: state_next = ST_IDLE;
      default: begin
        if (alu_done) begin
          case (state)
            ST_IVB, ST_HEC: state_next = (state == ST_IVB) ? ST_LVA : ST_CLS;
            ST_LVE: begin
              case (ret)
                RET_HE:   state_next = ST_HEA;
                RET_LOOP: state_next = ST_MFA;
                default:  state_next = ST_FNA;
              endcase
            end
            ST_MFK: state_next = ST_MCHK;
            ST_LQB, ST_FNB, ST_EUD, ST_SDA: state_next = ST_DONE;
            default: state_next = state_t'(state + 6'd1);
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DONE);
      if (req.go) pend <= 1'b1;
      else if (alu_done) pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      h    <= to_word({enthalpy[31], enthalpy});
      conc <= to_word({bulk_concentration[31], bulk_concentration});
      t    <= to_word({guess_temperature[31], guess_temperature});
      cnt  <= '0;
      flag <= 1'b0;
    end
    if (alu_done) begin
      case (step.dsel)
        DST_X:    x    <= alu_res;
        DST_Y:    y    <= alu_res;
        DST_H0:   h0   <= alu_res;
        DST_TLIQ: tliq <= alu_res;
        DST_TSOL: tsol <= alu_res;
        DST_HLIQ: hliq <= alu_res;
        DST_HSOL: hsol <= alu_res;
        DST_HE:   he   <= alu_res;
        DST_INV:  inv  <= alu_res;
        DST_F:    f    <= alu_res;
        DST_CL:   cl   <= alu_res;
        DST_T:    t    <= alu_res;
        DST_TN:   tn   <= alu_res;
        default: ;
      endcase
    end
    if (state == ST_IVB && alu_done) begin
      lv  <= te_w;
      ret <= RET_HE;
    end
    if (state == ST_CLS) begin
      if (h > hliq) begin
        region <= REG_LIQUID;
        f      <= ONE_W;
        cl     <= conc;
      end else if (h > he) begin
        region <= REG_MUSHY;
        lv     <= t;
        ret    <= RET_LOOP;
      end else if (h > hsol) begin
        region <= REG_EUTECTIC;
        t      <= te_w;
      end else begin
        region <= REG_SOLID;
        f      <= '0;
        cl     <= '0;
      end
    end
    if (state == ST_MCHK) begin
      t   <= tn;
      lv  <= tn;
      cnt <= cnt_inc;
      if (cnt_inc > {1'b0, iter_limit}) begin
        flag <= 1'b1;
        ret  <= RET_FINAL;
      end else if (x > TOL_W) begin
        ret <= RET_LOOP;
      end else begin
        ret <= RET_FINAL;
      end
    end
    if (state == ST_DONE) begin
      node_temperature     <= to_out(t);
      liquid_fraction      <= to_out(f);
      liquid_concentration <= to_out(cl);
      phase_region         <= region;
      limit_reached        <= (region == REG_MUSHY) ? flag : 1'b0;
      iterations_used      <= (region == REG_MUSHY) ? cnt : 9'd0;
    end
  end

  assign busy = (state != ST_IDLE);

  `ETTLR_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while sequencer busy")
  `ETTLR_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `ETTLR_ASSERT_NOW(a_flag_mushy, done && limit_reached,
                    phase_region == REG_MUSHY, "limit flag outside mushy region")
  `ETTLR_ASSERT_NEXT(a_one_issue, req.go, !req.go, "ALU issued twice for one step")

endmodule

// ===== rtl/ettlr_alu.sv =====
module ettlr_alu import ettlr_pkg::*; #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  alu_req_t                    req,
  input  logic signed [WORD_BITS-1:0] a,
  input  logic signed [WORD_BITS-1:0] b,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] result
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int N  = W + F;
  localparam int CW = $clog2(N + 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic          busy;
  logic          is_div;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [W-1:0]  x;
  logic [W-1:0]  hi;
  logic [W-1:0]  lo;
  logic [N-1:0]  dvd;
  logic [W:0]    rem;
  logic [N-1:0]  quo;

  logic [W-1:0]  mag_a, mag_b;
  logic [W:0]    msum;
  logic [W:0]    rshift;
  logic          rfit;
  logic [W:0]    rsub;

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] p,
                                                  input logic signed [W-1:0] q);
    logic [W:0] s;
    s = {p[W-1], p} + {q[W-1], q};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] p,
                                                  input logic signed [W-1:0] q);
    logic [W:0] s;
    s = {p[W-1], p} - {q[W-1], q};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  // magnitude to signed word with saturation
  function automatic logic signed [W-1:0] finish(input logic ng, input logic over,
                                                 input logic [W-1:0] m);
    if (!ng) return (over || m[W-1]) ? WMAX : m;
    if (over || (m[W-1] && (|m[W-2:0]))) return WMIN;
    return -m;
  endfunction

  assign mag_a  = a[W-1] ? -a : a;
  assign mag_b  = b[W-1] ? -b : b;
  assign msum   = {1'b0, hi} + (lo[0] ? {1'b0, x} : '0);
  assign rshift = {rem[W-1:0], dvd[N-1]};
  assign rfit   = rshift >= {1'b0, x};
  assign rsub   = rshift - {1'b0, x};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        neg    <= a[W-1] ^ b[W-1];
        is_div <= (req.op == ALU_DIV);
        case (req.op)
          ALU_ADD: begin
            result <= sat_add(a, b);
            done   <= 1'b1;
          end
          ALU_SUB: begin
            result <= sat_sub(a, b);
            done   <= 1'b1;
          end
          ALU_ABS: begin
            result <= a[W-1] ? sat_sub('0, a) : a;
            done   <= 1'b1;
          end
          ALU_MAX: begin
            result <= (a < b) ? b : a;
            done   <= 1'b1;
          end
          ALU_MUL: begin
            x    <= mag_a;
            hi   <= '0;
            lo   <= mag_b;
            cnt  <= CW'(W);
            busy <= 1'b1;
          end
          ALU_DIV: begin
            if (b == '0) begin
              result <= a[W-1] ? WMIN : WMAX;
              done   <= 1'b1;
            end else begin
              x    <= mag_b;
              dvd  <= {mag_a, {F{1'b0}}};
              rem  <= '0;
              quo  <= '0;
              cnt  <= CW'(N);
              busy <= 1'b1;
            end
          end
          default: begin
            result <= '0;
            done   <= 1'b1;
          end
        endcase
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (is_div) result <= finish(neg, |quo[N-1:W], quo[W-1:0]);
          else begin
            result <= finish(neg, |hi[W-1:F], {hi[F-1:0], lo[W-1:F]});
          end
        end else begin
          cnt <= cnt - 1'b1;
          if (is_div) begin
            rem <= rfit ? rsub : rshift;
            dvd <= {dvd[N-2:0], 1'b0};
            quo <= {quo[N-2:0], rfit};
          end else begin
            hi <= msum[W:1];
            lo <= {msum[0], lo[W-1:1]};
          end
        end
      end
    end
  end

endmodule
